[rtl/core/dual_command_fifo_with_bypass_macros.svh]
// assertion helpers used by the rtl top
`ifndef DUAL_COMMAND_FIFO_WITH_BYPASS_MACROS_SVH
`define DUAL_COMMAND_FIFO_WITH_BYPASS_MACROS_SVH

// same-cycle implication
`define DCFB_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("dcfb check failed");

// next-cycle implication
`define DCFB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("dcfb check failed");

`endif

[rtl/core/dcfb_pkg.sv]
`default_nettype none
package dcfb_pkg;

  localparam int unsigned MEM_WORDS_DEF = 65536;
  localparam int unsigned ENTRY_W       = 31;
  localparam int unsigned MAX_RESULTS   = 32;
  localparam logic [6:0]  TICK_CAP      = 7'd64;
  localparam logic [31:0] DRAIN_COST    = 32'd2;

  localparam logic CMD_BUS  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [1:0] ADDR_WINDOW = 2'd0;
  localparam logic [1:0] ADDR_FLAGS  = 2'd1;
  localparam logic [1:0] ADDR_LATCH  = 2'd2;
  localparam logic [1:0] ADDR_STORE  = 2'd3;

  localparam logic [1:0] CFG_MIXER_COST  = 2'd0;
  localparam logic [1:0] CFG_ACCEL_COST  = 2'd1;
  localparam logic [1:0] CFG_MIXER_SUSP  = 2'd2;
  localparam logic [1:0] CFG_ACCEL_SUSP  = 2'd3;

  localparam logic [1:0] TGT_MIXER   = 2'd0;
  localparam logic [1:0] TGT_ACCEL   = 2'd1;
  localparam logic [1:0] TGT_REINDEX = 2'd2;

  typedef struct packed {
    logic [1:0] target;
    logic [7:0] idx;
    logic       trig;
  } ds_t;

  // full 24-bit entry address, caller trims to the memory depth
  function automatic logic [23:0] entry_addr(input logic [15:0] ptr, input logic [15:0] win);
    logic [23:0] hi;
    hi = 24'hFFFFFF << ({1'b0, win[15:12]} + 5'd8);
    return ({8'd0, ptr} & ~hi) | ({win, 8'd0} & hi);
  endfunction

  function automatic ds_t decode(input logic ch, input logic [14:0] adr);
    ds_t d;
    if (!ch) begin
      d.target = TGT_MIXER;
      d.idx    = {4'd0, adr[3:0]};
      d.trig   = (adr[3:0] == 4'hF);
    end else if (!adr[8]) begin
      d.target = TGT_ACCEL;
      d.idx    = {3'd0, adr[4:0]};
      d.trig   = (adr[4:0] == 5'h1F);
    end else begin
      d.target = TGT_REINDEX;
      d.idx    = adr[7:0];
      d.trig   = 1'b0;
    end
    return d;
  endfunction

endpackage
`default_nettype wire

[rtl/core/dcfb_ram.sv]
`default_nettype none
module dcfb_ram #(
  parameter int unsigned Width = 31,
  parameter int unsigned Depth = 65536
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

[rtl/core/dual_command_fifo_with_bypass.sv]
// channel   | direction | handshake                   | payload
// command   | in        | start / busy                | cmd, bus_address, bus_value, tick_cycles
// result    | out       | result_valid_o strobe       | target, reg_index, reg_value, trigger, last
// config    | in        | cfg_valid_i / cfg_ready_o   | cfg_index_i, cfg_data_i
//
// bus writes finish in the accept cycle; a bypassed store shows its word on the next cycle
// a tick holds busy while it walks both channels: per drained entry an entry memory read and a
// decode, plus a step for each channel that pays off debt without draining, then a finish step;
// at most 32 words drain per tick, and its last word shows in the same cycle that busy drops
// rst_ni clears all control state at once; the entry memory is never cleared
// results are strobed for one cycle and cannot be stalled; config is always ready
`default_nettype none
`include "dual_command_fifo_with_bypass_macros.svh"
module dual_command_fifo_with_bypass #(
  parameter int unsigned MemWords = dcfb_pkg::MEM_WORDS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        cmd_i,
  input  wire logic [2:0]  bus_address_i,
  input  wire logic [15:0] bus_value_i,
  input  wire logic [6:0]  tick_cycles_i,
  output logic             result_valid_o,
  output logic [1:0]       target_o,
  output logic [7:0]       reg_index_o,
  output logic [15:0]      reg_value_o,
  output logic             trigger_o,
  output logic             last_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);
  import dcfb_pkg::*;

  localparam int unsigned AW = $clog2(MemWords);

  typedef enum logic [1:0] {ST_IDLE, ST_CHAN, ST_EMIT, ST_FIN} state_e;

  typedef struct packed {
    logic [1:0]  target;
    logic [7:0]  idx;
    logic [15:0] value;
    logic        trig;
  } res_t;

  state_e      state_q;
  logic        ch_q;
  logic [6:0]  cy_q;
  logic [5:0]  k_q;

  // per-channel state and the stall counter
  logic [15:0] wp_q [2];
  logic [15:0] rp_q [2];
  logic [14:0] latch_q [2];
  logic [15:0] win_q [2];
  logic        wf_q [2];
  logic [31:0] debt_q [2];
  logic [31:0] stall_q;

  logic [15:0] mix_cost_q, acc_cost_q;
  logic        mix_susp_q, acc_susp_q;

  // one-word hold so the last word of a tick can carry its last flag
  logic        pend_v_q;
  res_t        pend_q;

  logic        out_v_q, out_last_q;
  res_t        out_q;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;

  logic        accept;
  logic        bch;
  logic        bsusp, csusp;
  logic [31:0] ccost;
  logic [23:0] waddr_full, raddr_full;
  logic        drain_go;
  logic [6:0]  cy_cap;
  ds_t         bdec, edec;

  assign accept      = start && !busy;
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign bch         = bus_address_i[2];
  assign bsusp       = bch ? acc_susp_q : mix_susp_q;
  assign csusp       = ch_q ? acc_susp_q : mix_susp_q;
  assign ccost       = {16'd0, (ch_q ? acc_cost_q : mix_cost_q)};
  assign bdec        = decode(bch, latch_q[bch]);
  assign edec        = decode(ch_q, ram_rdata[30:16]);
  assign cy_cap      = (tick_cycles_i > TICK_CAP) ? TICK_CAP : tick_cycles_i;

  // a drain read fires when the channel's debt fits in the cycles left and entries wait
  assign drain_go = (state_q == ST_CHAN) && (cy_q != 7'd0) && (debt_q[ch_q] != 32'd0)
                    && (k_q != 6'(MAX_RESULTS)) && (debt_q[ch_q] <= {25'd0, cy_q})
                    && (rp_q[ch_q] != wp_q[ch_q]) && !csusp;

  always_comb begin
    waddr_full = entry_addr(wp_q[bch], win_q[bch]);
    raddr_full = entry_addr(rp_q[ch_q], win_q[ch_q]);
    ram_waddr  = waddr_full[AW-1:0];
    ram_raddr  = raddr_full[AW-1:0];
    ram_wdata  = {latch_q[bch], bus_value_i};
    ram_re     = drain_go;
    ram_we     = accept && (cmd_i == CMD_BUS) && (bus_address_i[1:0] == ADDR_STORE)
                 && ((debt_q[bch] != 32'd0) || wf_q[bch] || bsusp);
  end

  dcfb_ram #(.Width(ENTRY_W), .Depth(MemWords)) u_mem (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      ch_q       <= 1'b0;
      cy_q       <= '0;
      k_q        <= '0;
      for (int i = 0; i < 2; i++) begin
        wp_q[i]    <= '0;
        rp_q[i]    <= '0;
        latch_q[i] <= '0;
        win_q[i]   <= '0;
        wf_q[i]    <= 1'b0;
        debt_q[i]  <= '0;
      end
      stall_q    <= '0;
      mix_cost_q <= '0;
      acc_cost_q <= '0;
      mix_susp_q <= 1'b0;
      acc_susp_q <= 1'b0;
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      out_v_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_MIXER_COST: mix_cost_q <= cfg_data_i;
          CFG_ACCEL_COST: acc_cost_q <= cfg_data_i;
          CFG_MIXER_SUSP: mix_susp_q <= cfg_data_i[0];
          CFG_ACCEL_SUSP: acc_susp_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      case (state_q)
        ST_IDLE: begin
          if (accept && cmd_i == CMD_BUS) begin
            case (bus_address_i[1:0])
              ADDR_WINDOW: win_q[bch] <= bus_value_i;
              ADDR_LATCH: begin
                if (bus_value_i[15]) latch_q[bch] <= latch_q[bch] + 15'd1;
                else latch_q[bch] <= bus_value_i[14:0];
              end
              ADDR_STORE: begin
                latch_q[bch] <= latch_q[bch] + 15'd1;
                if (ram_we) begin
                  wp_q[bch] <= wp_q[bch] + 16'd1;
                  stall_q   <= stall_q + 32'd2;
                end else begin
                  // bypass straight downstream
                  out_v_q      <= 1'b1;
                  out_last_q   <= 1'b1;
                  out_q.target <= bdec.target;
                  out_q.idx    <= bdec.idx;
                  out_q.value  <= bus_value_i;
                  out_q.trig   <= bdec.trig;
                  if (bdec.trig) begin
                    debt_q[bch] <= debt_q[bch] + {16'd0, (bch ? acc_cost_q : mix_cost_q)};
                    wf_q[bch]   <= 1'b1;
                  end
                end
              end
              default: ;
            endcase
          end else if (accept) begin
            // stall cycles are paid first
            if (stall_q >= {25'd0, cy_cap}) begin
              stall_q <= stall_q - {25'd0, cy_cap};
              cy_q    <= '0;
            end else begin
              cy_q    <= cy_cap - stall_q[6:0];
              stall_q <= '0;
            end
            ch_q    <= 1'b0;
            k_q     <= '0;
            state_q <= ST_CHAN;
          end
        end
        ST_CHAN: begin
          if (cy_q == 7'd0 || debt_q[ch_q] == 32'd0 || k_q == 6'(MAX_RESULTS)) begin
            if (ch_q) state_q <= ST_FIN;
            else ch_q <= 1'b1;
          end else if (debt_q[ch_q] > {25'd0, cy_q}) begin
            debt_q[ch_q] <= debt_q[ch_q] - {25'd0, cy_q};
            cy_q         <= '0;
          end else begin
            cy_q         <= cy_q - debt_q[ch_q][6:0];
            debt_q[ch_q] <= '0;
            if (rp_q[ch_q] == wp_q[ch_q]) begin
              wf_q[ch_q] <= 1'b0;
            end else if (drain_go) begin
              rp_q[ch_q]   <= rp_q[ch_q] + 16'd1;
              debt_q[ch_q] <= DRAIN_COST;
              state_q      <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (edec.trig) begin
            debt_q[ch_q] <= DRAIN_COST + ccost;
            wf_q[ch_q]   <= 1'b1;
          end
          if (pend_v_q) begin
            out_v_q    <= 1'b1;
            out_last_q <= 1'b0;
            out_q      <= pend_q;
          end
          pend_v_q      <= 1'b1;
          pend_q.target <= edec.target;
          pend_q.idx    <= edec.idx;
          pend_q.value  <= ram_rdata[15:0];
          pend_q.trig   <= edec.trig;
          k_q           <= k_q + 6'd1;
          state_q       <= ST_CHAN;
        end
        ST_FIN: begin
          if (pend_v_q) begin
            out_v_q    <= 1'b1;
            out_last_q <= 1'b1;
            out_q      <= pend_q;
          end
          pend_v_q <= 1'b0;
          state_q  <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign result_valid_o = out_v_q;
  assign target_o       = out_q.target;
  assign reg_index_o    = out_q.idx;
  assign reg_value_o    = out_q.value;
  assign trigger_o      = out_q.trig;
  assign last_o         = out_last_q;

  `DCFB_ASSERT_NOW(a_trig_not_table, clk_i, rst_ni, result_valid_o && trigger_o, target_o != TGT_REINDEX)
  `DCFB_ASSERT_NEXT(a_tick_goes_busy, clk_i, rst_ni, start && !busy && cmd_i == CMD_TICK, busy)
  `DCFB_ASSERT_NOW(a_result_bound, clk_i, rst_ni, state_q == ST_EMIT, k_q < 6'(MAX_RESULTS))
  `DCFB_ASSERT_NOW(a_no_pend_idle, clk_i, rst_ni, state_q == ST_IDLE, !pend_v_q)
endmodule
`default_nettype wire
